@@ design/rsd_pkg.sv @@
// shared types and constants for the run-skip-dump decoder
`default_nettype none

package rsd_pkg;

  localparam int RSD_ADDR_BITS = 16;

  // result kind codes
  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_FILL    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_start;
  } rsd_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] out_address;
    logic [13:0] out_length;
    logic [7:0]  out_value;
  } rsd_out_t;

endpackage

`default_nettype wire

@@ design/rsd_parser.sv @@
// byte parser: parse state, write position and the decode of one byte per cycle while take is high
`default_nettype none

module rsd_parser #(
  parameter int ADDR_BITS = rsd_pkg::RSD_ADDR_BITS
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            take,
  input  rsd_pkg::rsd_in_t  item,
  output logic           res_valid,
  output rsd_pkg::rsd_out_t res
);
  import rsd_pkg::*;

  typedef enum logic [3:0] {
    PH_OPCODE   = 4'd0,
    PH_DUMP     = 4'd1,
    PH_RUN_CNT  = 4'd2,
    PH_RUN_VAL  = 4'd3,
    PH_LONG_LO  = 4'd4,
    PH_LONG_HI  = 4'd5,
    PH_LRUN_VAL = 4'd6,
    PH_STOPPED  = 4'd7
  } phase_t;

  phase_t                 phase_r, phase_nxt, phase_eff;
  logic [13:0]            cnt_r, cnt_nxt, cnt_eff, cnt_dec;
  logic [ADDR_BITS-1:0]   pos_r, pos_nxt, pos_eff;
  logic [7:0]             low_r, low_nxt;
  logic [14:0]            inc;
  logic [15:0]            word;
  logic [7:0]             b;

  assign b    = item.in_byte;
  assign word = {b, low_r};
  assign cnt_dec = cnt_eff - 14'd1;

  always_comb begin
    // frame start rewinds before the byte is parsed
    phase_eff = item.frame_start ? PH_OPCODE : phase_r;
    cnt_eff   = item.frame_start ? 14'd0 : cnt_r;
    pos_eff   = item.frame_start ? '0 : pos_r;

    phase_nxt = phase_eff;
    cnt_nxt   = cnt_eff;
    low_nxt   = low_r;
    inc       = '0;
    res_valid = 1'b0;
    res.out_kind    = KIND_LITERAL;
    res.out_address = 16'(pos_eff);
    res.out_length  = 14'd1;
    res.out_value   = b;

    unique case (phase_eff)
      PH_DUMP: begin
        res_valid = 1'b1;
        inc       = 15'd1;
        cnt_nxt   = cnt_dec;
        if (cnt_dec == 14'd0) phase_nxt = PH_OPCODE;
      end
      PH_RUN_CNT: begin
        cnt_nxt   = {6'd0, b};
        phase_nxt = PH_RUN_VAL;
      end
      PH_RUN_VAL, PH_LRUN_VAL: begin
        if (cnt_eff != 14'd0) begin
          res_valid      = 1'b1;
          res.out_kind   = KIND_FILL;
          res.out_length = cnt_eff;
          inc            = {1'b0, cnt_eff};
        end
        cnt_nxt   = 14'd0;
        phase_nxt = PH_OPCODE;
      end
      PH_LONG_LO: begin
        low_nxt   = b;
        phase_nxt = PH_LONG_HI;
      end
      PH_LONG_HI: begin
        phase_nxt = PH_OPCODE;
        if (word == 16'd0) begin
          res_valid      = 1'b1;
          res.out_kind   = KIND_END;
          res.out_length = 14'd0;
          res.out_value  = 8'd0;
          phase_nxt      = PH_STOPPED;
        end else if (!word[15]) begin
          inc = word[14:0];
        end else if (!word[14]) begin
          cnt_nxt = word[13:0];
          if (word[13:0] != 14'd0) phase_nxt = PH_DUMP;
        end else begin
          cnt_nxt   = word[13:0];
          phase_nxt = PH_LRUN_VAL;
        end
      end
      PH_STOPPED: begin
        phase_nxt = PH_STOPPED;
      end
      default: begin
        // opcode phase, and any unused phase code
        if (b == 8'h00) begin
          phase_nxt = PH_RUN_CNT;
        end else if (!b[7]) begin
          cnt_nxt   = {6'd0, b};
          phase_nxt = PH_DUMP;
        end else if (b == 8'h80) begin
          phase_nxt = PH_LONG_LO;
        end else begin
          inc       = {8'd0, b[6:0]};
          phase_nxt = PH_OPCODE;
        end
      end
    endcase

    // position wraps at the buffer size
    pos_nxt = pos_eff + ADDR_BITS'(inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPCODE;
      cnt_r   <= 14'd0;
      pos_r   <= '0;
      low_r   <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/run_skip_dump_decoder.sv @@
// top level of the run-skip-dump frame decoder
`default_nettype none

// Decodes a run-skip-dump compressed frame one byte per transaction and emits
// literal writes, fill commands and an end-of-frame marker. A byte is taken
// into an input register, parsed combinationally from there, and its result (if
// any) lands in an output register. Sustained rate is one byte per cycle while
// the output is not stalled: the parse state and write position update once per
// byte. Bytes that cause no result (opcodes, counts, skips, bytes after a stop)
// still pass through the input register and the parser. The write position is
// ADDR_BITS wide and wraps; out_address shows its low 16 bits.
module run_skip_dump_decoder #(
  parameter int ADDR_BITS = rsd_pkg::RSD_ADDR_BITS
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  rsd_pkg::rsd_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output rsd_pkg::rsd_out_t  out_data
);
  import rsd_pkg::*;

  logic      in_valid_r;
  rsd_in_t   in_data_r;
  logic      out_valid_r;
  rsd_out_t  out_data_r;
  logic      advance;
  logic      take;
  logic      res_valid;
  rsd_out_t  res;

  // the held byte moves on when the output register is free or being emptied
  assign advance  = !out_valid_r || !out_stall;
  assign take     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
  end

  rsd_parser #(
    .ADDR_BITS (ADDR_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (in_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/rsd_checker.sv @@
// port-level checks for the run-skip-dump decoder, bound to the top level
`default_nettype none

module rsd_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_stall,
  input rsd_pkg::rsd_out_t  out_data
);
  import rsd_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_kind == KIND_LITERAL ||
                   out_data.out_kind == KIND_FILL ||
                   out_data.out_kind == KIND_END))
    else $error("unknown result kind");

  a_literal_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_LITERAL |-> out_data.out_length == 14'd1)
    else $error("literal write with length other than one");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_FILL |-> out_data.out_length != 14'd0)
    else $error("fill with zero length");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == KIND_END |->
      out_data.out_length == 14'd0 && out_data.out_value == 8'd0)
    else $error("end marker carries length or value");

endmodule

bind run_skip_dump_decoder rsd_checker u_rsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
